// ===== rtl/relative_gradient_density_assert.svh =====
// ----------------------------------------------------------------------------
// relative gradient density assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef RELATIVE_GRADIENT_DENSITY_ASSERT_SVH
`define RELATIVE_GRADIENT_DENSITY_ASSERT_SVH

`ifndef SYNTHESIS
`define RGD_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rgd check failed");
`define RGD_ASSERT_NEVER(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("rgd forbidden condition");
`else
`define RGD_ASSERT(name, clk, rstn, prop)
`define RGD_ASSERT_NEVER(name, clk, rstn, expr)
`endif

`endif

// ===== rtl/rgd_pkg.sv =====
// ----------------------------------------------------------------------------
// rgd_pkg
// shared constants and types of the relative gradient density pipeline
// ----------------------------------------------------------------------------
package rgd_pkg;

  localparam int unsigned DIM_W      = 15;
  localparam int unsigned MAG_W      = 32;
  localparam int unsigned K_W        = 32;
  localparam int unsigned FRAC_W     = 32;
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned SQRT_STEPS = 32;

  // 4 * 4096^2
  localparam logic [K_W-1:0]   K_RESET = 32'h0400_0000;
  localparam logic [MAG_W-1:0] MAG_ONE = 32'h0001_0000;
  localparam logic [MAG_W-1:0] MAG_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic vld;
    logic zero;
    logic ovf;
  } ctl_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             saturated;
  } res_t;

endpackage

// ===== rtl/rgd_if.sv =====
// ----------------------------------------------------------------------------
// rgd channel interfaces
// valid/ready channels for neighbour input and density output
// ----------------------------------------------------------------------------
interface rgd_in_if #(parameter int LW = 16);
  logic          valid;
  logic          ready;
  logic [LW-1:0] left_luma;
  logic [LW-1:0] right_luma;
  logic [LW-1:0] up_luma;
  logic [LW-1:0] down_luma;

  modport source (output valid, left_luma, right_luma, up_luma, down_luma,
                  input ready);
  modport sink (input valid, left_luma, right_luma, up_luma, down_luma,
                output ready);
endinterface

interface rgd_out_if;
  logic                     valid;
  logic                     ready;
  logic [rgd_pkg::MAG_W-1:0] magnitude;
  logic                     saturated;

  modport source (output valid, magnitude, saturated, input ready);
  modport sink (input valid, magnitude, saturated, output ready);
endinterface

// ===== rtl/rgd_front.sv =====
// ----------------------------------------------------------------------------
// rgd_front
// differences, sum, squares, scaled gradient product and overflow test
// ----------------------------------------------------------------------------
module rgd_front #(
  parameter int LUMA_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     in_valid_i,
  input  logic [LUMA_WIDTH-1:0]    left_luma_i,
  input  logic [LUMA_WIDTH-1:0]    right_luma_i,
  input  logic [LUMA_WIDTH-1:0]    up_luma_i,
  input  logic [LUMA_WIDTH-1:0]    down_luma_i,
  input  logic [rgd_pkg::K_W-1:0]  k_i,
  output rgd_pkg::ctl_t            ctl_o,
  output logic [rgd_pkg::K_W+2*LUMA_WIDTH:0] t_o,
  output logic [2*LUMA_WIDTH+3:0]  s2_o
);

  localparam int SW     = LUMA_WIDTH + 2;
  localparam int S2W    = 2 * SW;
  localparam int QW     = 2 * LUMA_WIDTH + 1;
  localparam int QLW    = QW / 2;
  localparam int QHW    = QW - QLW;
  localparam int TW     = rgd_pkg::K_W + QW;
  localparam int LIMW   = S2W + rgd_pkg::FRAC_W;
  localparam int CW     = (TW > LIMW) ? TW : LIMW;
  localparam int NSTAGE = 6;

  logic [NSTAGE-1:0] v_q;

  logic [LUMA_WIDTH-1:0] adx_d, ady_d, adx_q, ady_q;
  logic [SW-1:0]         s_d, s_q;
  logic [2*LUMA_WIDTH-1:0] a2_q, b2_q;
  logic [S2W-1:0]        s2_2_q, s2_3_q, s2_4_q, s2_5_q, s2_6_q;
  logic                  z2_q, z3_q, z4_q, z5_q, z6_q;
  logic [QW-1:0]         q3_q;
  logic [rgd_pkg::K_W+QLW-1:0] ppl_q;
  logic [rgd_pkg::K_W+QHW-1:0] pph_q;
  logic [TW-1:0]         t5_q, t6_q;
  logic [CW-1:0]         lim5_q;
  logic                  ovf6_q;

  always_comb begin
    adx_d = (left_luma_i >= right_luma_i) ? left_luma_i - right_luma_i
                                          : right_luma_i - left_luma_i;
    ady_d = (up_luma_i >= down_luma_i) ? up_luma_i - down_luma_i
                                       : down_luma_i - up_luma_i;
    s_d   = SW'(left_luma_i) + SW'(right_luma_i) + SW'(up_luma_i) + SW'(down_luma_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NSTAGE-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adx_q  <= adx_d;
      ady_q  <= ady_d;
      s_q    <= s_d;

      a2_q   <= (2*LUMA_WIDTH)'(adx_q) * (2*LUMA_WIDTH)'(adx_q);
      b2_q   <= (2*LUMA_WIDTH)'(ady_q) * (2*LUMA_WIDTH)'(ady_q);
      s2_2_q <= S2W'(s_q) * S2W'(s_q);
      z2_q   <= (s_q == '0);

      q3_q   <= QW'(a2_q) + QW'(b2_q);
      s2_3_q <= s2_2_q;
      z3_q   <= z2_q;

      // gradient product split in two partial products
      ppl_q  <= (rgd_pkg::K_W+QLW)'(k_i) * (rgd_pkg::K_W+QLW)'(q3_q[QLW-1:0]);
      pph_q  <= (rgd_pkg::K_W+QHW)'(k_i) * (rgd_pkg::K_W+QHW)'(q3_q[QW-1:QLW]);
      s2_4_q <= s2_3_q;
      z4_q   <= z3_q;

      t5_q   <= (TW'(pph_q) << QLW) + TW'(ppl_q);
      // (2^32 - 1) * s^2
      lim5_q <= (CW'(s2_4_q) << rgd_pkg::FRAC_W) - CW'(s2_4_q);
      s2_5_q <= s2_4_q;
      z5_q   <= z4_q;

      ovf6_q <= CW'(t5_q) >= lim5_q;
      t6_q   <= t5_q;
      s2_6_q <= s2_5_q;
      z6_q   <= z5_q;
    end
  end

  assign ctl_o = '{vld: v_q[NSTAGE-1], zero: z6_q, ovf: ovf6_q};
  assign t_o   = t6_q;
  assign s2_o  = s2_6_q;

endmodule

// ===== rtl/rgd_div.sv =====
// ----------------------------------------------------------------------------
// rgd_div
// restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
module rgd_div #(
  parameter int LUMA_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  rgd_pkg::ctl_t            ctl_i,
  input  logic [rgd_pkg::K_W+2*LUMA_WIDTH:0] t_i,
  input  logic [2*LUMA_WIDTH+3:0]  s2_i,
  output rgd_pkg::ctl_t            ctl_o,
  output logic [rgd_pkg::DIV_STEPS-1:0] quo_o
);

  localparam int S2W = 2 * (LUMA_WIDTH + 2);
  localparam int TW  = rgd_pkg::K_W + 2 * LUMA_WIDTH + 1;
  localparam int NS  = rgd_pkg::DIV_STEPS;

  logic [NS-1:0]  v_q, z_q, o_q;
  logic [S2W-1:0] rem_q [NS];
  logic [S2W-1:0] dvs_q [NS];
  logic [NS-1:0]  sh_q  [NS];
  logic [NS-1:0]  quo_q [NS];

  logic [S2W-1:0] rem_in [NS];
  logic [S2W-1:0] dvs_in [NS];
  logic [NS-1:0]  sh_in  [NS];
  logic [NS-1:0]  quo_in [NS];
  logic [NS-1:0]  v_in, z_in, o_in;

  logic [TW-1:0]  t_hi;

  // without overflow the upper part of the dividend stays below the divisor
  assign t_hi = t_i >> rgd_pkg::FRAC_W;

  for (genvar j = 0; j < NS; j++) begin : g_step
    logic [S2W:0]   r1;
    logic           ge;
    logic [S2W:0]   rn;

    if (j == 0) begin : g_first
      assign rem_in[j] = t_hi[S2W-1:0];
      assign dvs_in[j] = s2_i;
      assign sh_in[j]  = {t_i[rgd_pkg::FRAC_W-1:0], {(NS-rgd_pkg::FRAC_W){1'b0}}};
      assign quo_in[j] = '0;
      assign v_in[j]   = ctl_i.vld;
      assign z_in[j]   = ctl_i.zero;
      assign o_in[j]   = ctl_i.ovf;
    end else begin : g_next
      assign rem_in[j] = rem_q[j-1];
      assign dvs_in[j] = dvs_q[j-1];
      assign sh_in[j]  = sh_q[j-1];
      assign quo_in[j] = quo_q[j-1];
      assign v_in[j]   = v_q[j-1];
      assign z_in[j]   = z_q[j-1];
      assign o_in[j]   = o_q[j-1];
    end

    always_comb begin
      r1 = {rem_in[j], sh_in[j][NS-1]};
      ge = r1 >= {1'b0, dvs_in[j]};
      rn = ge ? r1 - {1'b0, dvs_in[j]} : r1;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rn[S2W-1:0];
        dvs_q[j] <= dvs_in[j];
        sh_q[j]  <= sh_in[j] << 1;
        quo_q[j] <= {quo_in[j][NS-2:0], ge};
        z_q[j]   <= z_in[j];
        o_q[j]   <= o_in[j];
      end
    end
  end

  assign ctl_o = '{vld: v_q[NS-1], zero: z_q[NS-1], ovf: o_q[NS-1]};
  assign quo_o = quo_q[NS-1];

endmodule

// ===== rtl/rgd_sqrt.sv =====
// ----------------------------------------------------------------------------
// rgd_sqrt
// adds the unit term, then a digit-by-digit square root, one root bit per stage
// ----------------------------------------------------------------------------
module rgd_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  rgd_pkg::ctl_t                 ctl_i,
  input  logic [rgd_pkg::DIV_STEPS-1:0] quo_i,
  output rgd_pkg::ctl_t                 ctl_o,
  output rgd_pkg::res_t                 res_o
);

  localparam int NS   = rgd_pkg::SQRT_STEPS;
  localparam int XW   = 2 * NS;
  localparam int RMW  = NS + 3;

  logic          va_q, za_q, oa_q;
  logic [XW-1:0] x_q;

  logic [NS-1:0]  v_q, z_q, o_q;
  logic [RMW-1:0] rem_q  [NS];
  logic [NS-1:0]  root_q [NS];
  logic [XW-1:0]  sh_q   [NS];

  logic [RMW-1:0] rem_in  [NS];
  logic [NS-1:0]  root_in [NS];
  logic [XW-1:0]  sh_in   [NS];
  logic [NS-1:0]  v_in, z_in, o_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= XW'(quo_i) + (XW'(1) << rgd_pkg::FRAC_W);
      za_q <= ctl_i.zero;
      oa_q <= ctl_i.ovf;
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_step
    logic [RMW-1:0] r2, trial, rn;
    logic           ge;

    if (j == 0) begin : g_first
      assign rem_in[j]  = '0;
      assign root_in[j] = '0;
      assign sh_in[j]   = x_q;
      assign v_in[j]    = va_q;
      assign z_in[j]    = za_q;
      assign o_in[j]    = oa_q;
    end else begin : g_next
      assign rem_in[j]  = rem_q[j-1];
      assign root_in[j] = root_q[j-1];
      assign sh_in[j]   = sh_q[j-1];
      assign v_in[j]    = v_q[j-1];
      assign z_in[j]    = z_q[j-1];
      assign o_in[j]    = o_q[j-1];
    end

    always_comb begin
      r2    = {rem_in[j][RMW-3:0], sh_in[j][XW-1:XW-2]};
      trial = RMW'({root_in[j], 2'b01});
      ge    = r2 >= trial;
      rn    = ge ? r2 - trial : r2;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rn;
        root_q[j] <= {root_in[j][NS-2:0], ge};
        sh_q[j]   <= sh_in[j] << 2;
        z_q[j]    <= z_in[j];
        o_q[j]    <= o_in[j];
      end
    end
  end

  assign ctl_o = '{vld: v_q[NS-1], zero: z_q[NS-1], ovf: o_q[NS-1]};

  always_comb begin
    priority if (z_q[NS-1]) begin
      res_o = '{magnitude: rgd_pkg::MAG_ONE, saturated: 1'b0};
    end else if (o_q[NS-1]) begin
      res_o = '{magnitude: rgd_pkg::MAG_MAX, saturated: 1'b1};
    end else begin
      res_o = '{magnitude: root_q[NS-1], saturated: 1'b0};
    end
  end

endmodule

// ===== rtl/relative_gradient_density.sv =====
// pipeline: 6 front stages, 64 divider stages, 33 square-root stages, one output register
// throughput: one transaction per cycle while the skid entry is empty, else the whole
//   pipeline stalls; the divider and root each retire one bit per stage, and a two-entry
//   output register/skid keeps input ready registered
// reset: asynchronous active low, clears all valid bits and loads k = 4 * 4096^2 (dimension 4096)
// ----------------------------------------------------------------------------
// relative_gradient_density
// per-pixel relative gradient density from four cross neighbours, Q16.16 out
// ----------------------------------------------------------------------------
module relative_gradient_density #(
  parameter int LUMA_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  rgd_in_if.sink                    in_chan,
  rgd_out_if.source                 out_chan,
  input  logic                      cfg_we_i,
  input  logic [rgd_pkg::DIM_W-1:0] cfg_wdata_i
);

  localparam int S2W = 2 * (LUMA_WIDTH + 2);
  localparam int TW  = rgd_pkg::K_W + 2 * LUMA_WIDTH + 1;

  logic [rgd_pkg::K_W-1:0] k_q, k_d;
  logic                    en;

  rgd_pkg::ctl_t               fr_ctl, dv_ctl, sq_ctl;
  logic [TW-1:0]               fr_t;
  logic [S2W-1:0]              fr_s2;
  logic [rgd_pkg::DIV_STEPS-1:0] dv_quo;
  rgd_pkg::res_t               sq_res;

  logic          out_v_q, out_v_d, sk_v_q, sk_v_d, p_v;
  rgd_pkg::res_t out_res_q, out_res_d, sk_res_q, sk_res_d;

  // 4 * D^2 held ready for the pipeline
  assign k_d = {(2*rgd_pkg::DIM_W)'(cfg_wdata_i) * (2*rgd_pkg::DIM_W)'(cfg_wdata_i), 2'b00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= rgd_pkg::K_RESET;
    end else if (cfg_we_i) begin
      k_q <= k_d;
    end
  end

  assign en            = !sk_v_q;
  assign in_chan.ready = en;

  rgd_front #(.LUMA_WIDTH(LUMA_WIDTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .in_valid_i   (in_chan.valid),
    .left_luma_i  (in_chan.left_luma),
    .right_luma_i (in_chan.right_luma),
    .up_luma_i    (in_chan.up_luma),
    .down_luma_i  (in_chan.down_luma),
    .k_i          (k_q),
    .ctl_o        (fr_ctl),
    .t_o          (fr_t),
    .s2_o         (fr_s2)
  );

  rgd_div #(.LUMA_WIDTH(LUMA_WIDTH)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (fr_ctl),
    .t_i    (fr_t),
    .s2_i   (fr_s2),
    .ctl_o  (dv_ctl),
    .quo_o  (dv_quo)
  );

  rgd_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (dv_ctl),
    .quo_i  (dv_quo),
    .ctl_o  (sq_ctl),
    .res_o  (sq_res)
  );

  assign p_v = sq_ctl.vld & en;

  // output register with skid entry
  always_comb begin
    out_v_d   = out_v_q;
    out_res_d = out_res_q;
    sk_v_d    = sk_v_q;
    sk_res_d  = sk_res_q;
    if (!out_v_q || out_chan.ready) begin
      if (sk_v_q) begin
        out_v_d   = 1'b1;
        out_res_d = sk_res_q;
        sk_v_d    = 1'b0;
      end else begin
        out_v_d   = p_v;
        out_res_d = sq_res;
      end
    end else if (p_v) begin
      sk_v_d   = 1'b1;
      sk_res_d = sq_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      sk_v_q  <= sk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
    sk_res_q  <= sk_res_d;
  end

  assign out_chan.valid     = out_v_q;
  assign out_chan.magnitude = out_res_q.magnitude;
  assign out_chan.saturated = out_res_q.saturated;

`include "relative_gradient_density_assert.svh"

  `RGD_ASSERT_NEVER(a_skid_without_out, clk_i, rst_ni, sk_v_q && !out_v_q)
  `RGD_ASSERT(a_sat_is_max, clk_i, rst_ni, out_v_q && out_res_q.saturated |-> out_res_q.magnitude == rgd_pkg::MAG_MAX)
  `RGD_ASSERT(a_out_drop_on_take, clk_i, rst_ni, $fell(out_v_q) |-> $past(out_chan.ready))
  `RGD_ASSERT(a_skid_fill_on_stall, clk_i, rst_ni, $rose(sk_v_q) |-> $past(out_v_q && !out_chan.ready))

endmodule
